@@ rtl/scid_pkg.sv @@
// Shared types, mnemonic numbers and opcode class table for the instruction decoder.
package scid_pkg;

	localparam int unsigned WordW  = 32;
	localparam int unsigned MnemW  = 7;
	localparam int unsigned RegW   = 5;
	localparam int unsigned ImmW   = 16;
	localparam int unsigned FlagW  = 5;
	localparam int unsigned OffW   = 4;

	// Mnemonic numbers (single ones and bases of sub-decoded groups)
	localparam logic [MnemW-1:0] MN_ADD    = 7'd0,   MN_RSUB   = 7'd1,   MN_ADDC   = 7'd2;
	localparam logic [MnemW-1:0] MN_RSUBC  = 7'd3,   MN_ADDK   = 7'd4,   MN_CMP    = 7'd5;
	localparam logic [MnemW-1:0] MN_ADDKC  = 7'd8,   MN_RSUBKC = 7'd9,   MN_ADDI   = 7'd10;
	localparam logic [MnemW-1:0] MN_RSUBI  = 7'd11,  MN_ADDIC  = 7'd12,  MN_RSUBIC = 7'd13;
	localparam logic [MnemW-1:0] MN_ADDIK  = 7'd14,  MN_RSUBIK = 7'd15,  MN_ADDIKC = 7'd16;
	localparam logic [MnemW-1:0] MN_RSUBIKC= 7'd17,  MN_MUL    = 7'd18,  MN_BSRA   = 7'd22;
	localparam logic [MnemW-1:0] MN_IDIV   = 7'd24,  MN_GETD   = 7'd26,  MN_FADD   = 7'd28;
	localparam logic [MnemW-1:0] MN_MULI   = 7'd42,  MN_BSRLI  = 7'd43,  MN_GET    = 7'd46;
	localparam logic [MnemW-1:0] MN_OR     = 7'd48,  MN_AND    = 7'd50,  MN_XOR    = 7'd51;
	localparam logic [MnemW-1:0] MN_ANDN   = 7'd53,  MN_SRA    = 7'd55,  MN_MTS    = 7'd62;
	localparam logic [MnemW-1:0] MN_MFS    = 7'd63,  MN_MSRCLR = 7'd64,  MN_MSRSET = 7'd65;
	localparam logic [MnemW-1:0] MN_BR     = 7'd66,  MN_BEQ    = 7'd73,  MN_ORI    = 7'd85;
	localparam logic [MnemW-1:0] MN_ANDI   = 7'd86,  MN_XORI   = 7'd87,  MN_ANDNI  = 7'd88;
	localparam logic [MnemW-1:0] MN_IMM    = 7'd89,  MN_RTSD   = 7'd90,  MN_BRI    = 7'd94;
	localparam logic [MnemW-1:0] MN_BEQI   = 7'd101, MN_LBU    = 7'd113, MN_LHU    = 7'd114;
	localparam logic [MnemW-1:0] MN_LW     = 7'd115, MN_SB     = 7'd116, MN_SH     = 7'd117;
	localparam logic [MnemW-1:0] MN_SW     = 7'd118, MN_LBUI   = 7'd119, MN_LHUI   = 7'd120;
	localparam logic [MnemW-1:0] MN_LWI    = 7'd121, MN_SBI    = 7'd122, MN_SHI    = 7'd123;
	localparam logic [MnemW-1:0] MN_SWI    = 7'd124;

	// Last list position of immediate branches that is pc-relative
	localparam logic [OffW-1:0] BRI_REL_LAST = 4'd2;

	// Special register form select (imm bits 15..14) and msr ra values
	localparam logic [1:0] SPR_MTS = 2'd3;
	localparam logic [1:0] SPR_MFS = 2'd2;
	localparam logic [1:0] SPR_MSR = 2'd0;
	localparam logic [RegW-1:0] RA_MSRCLR = 5'h11;
	localparam logic [RegW-1:0] RA_MSRSET = 5'h10;

	typedef enum logic [4:0] {
		K_INV, K_A, K_B, K_CMP, K_MUL, K_BS, K_IDIV, K_GETD, K_FLT, K_BSI,
		K_GET, K_POR, K_PXOR, K_PANDN, K_MISC, K_SPR, K_BRA, K_BRAC, K_IMM,
		K_RT, K_BRI, K_BRIC
	} kind_t;

	typedef struct packed {
		kind_t            kind;
		logic [MnemW-1:0] id;
	} op_class_t;

	typedef struct packed {
		logic             hit;
		logic [OffW-1:0]  off;
	} lookup_t;

	// Decoded result of one word
	typedef struct packed {
		logic              valid_res;
		logic [MnemW-1:0]  mnemonic_id;
		logic [RegW-1:0]   rd;
		logic [RegW-1:0]   ra;
		logic [RegW-1:0]   rb;
		logic [ImmW-1:0]   imm_value;
		logic [WordW-1:0]  branch_target;
		logic [FlagW-1:0]  mod_flags;
	} dec_res_t;

	function automatic op_class_t mk(input kind_t k, input logic [MnemW-1:0] id);
		op_class_t c;
		c.kind = k;
		c.id   = id;
		return c;
	endfunction

	// Primary opcode class table
	function automatic op_class_t prim_class(input logic [5:0] opc);
		op_class_t c;
		c = mk(K_INV, MN_ADD);
		unique case (opc)
			6'd0:  c = mk(K_A, MN_ADD);
			6'd1:  c = mk(K_A, MN_RSUB);
			6'd2:  c = mk(K_A, MN_ADDC);
			6'd3:  c = mk(K_A, MN_RSUBC);
			6'd4:  c = mk(K_A, MN_ADDK);
			6'd5:  c = mk(K_CMP, MN_CMP);
			6'd6:  c = mk(K_A, MN_ADDKC);
			6'd7:  c = mk(K_A, MN_RSUBKC);
			6'd8:  c = mk(K_B, MN_ADDI);
			6'd9:  c = mk(K_B, MN_RSUBI);
			6'd10: c = mk(K_B, MN_ADDIC);
			6'd11: c = mk(K_B, MN_RSUBIC);
			6'd12: c = mk(K_B, MN_ADDIK);
			6'd13: c = mk(K_B, MN_RSUBIK);
			6'd14: c = mk(K_B, MN_ADDIKC);
			6'd15: c = mk(K_B, MN_RSUBIKC);
			6'd16: c = mk(K_MUL, MN_MUL);
			6'd17: c = mk(K_BS, MN_BSRA);
			6'd18: c = mk(K_IDIV, MN_IDIV);
			6'd19: c = mk(K_GETD, MN_GETD);
			6'd22: c = mk(K_FLT, MN_FADD);
			6'd24: c = mk(K_B, MN_MULI);
			6'd25: c = mk(K_BSI, MN_BSRLI);
			6'd27: c = mk(K_GET, MN_GET);
			6'd32: c = mk(K_POR, MN_OR);
			6'd33: c = mk(K_A, MN_AND);
			6'd34: c = mk(K_PXOR, MN_XOR);
			6'd35: c = mk(K_PANDN, MN_ANDN);
			6'd36: c = mk(K_MISC, MN_SRA);
			6'd37: c = mk(K_SPR, MN_MTS);
			6'd38: c = mk(K_BRA, MN_BR);
			6'd39: c = mk(K_BRAC, MN_BEQ);
			6'd40: c = mk(K_B, MN_ORI);
			6'd41: c = mk(K_B, MN_ANDI);
			6'd42: c = mk(K_B, MN_XORI);
			6'd43: c = mk(K_B, MN_ANDNI);
			6'd44: c = mk(K_IMM, MN_IMM);
			6'd45: c = mk(K_RT, MN_RTSD);
			6'd46: c = mk(K_BRI, MN_BRI);
			6'd47: c = mk(K_BRIC, MN_BEQI);
			6'd48: c = mk(K_A, MN_LBU);
			6'd49: c = mk(K_A, MN_LHU);
			6'd50: c = mk(K_A, MN_LW);
			6'd52: c = mk(K_A, MN_SB);
			6'd53: c = mk(K_A, MN_SH);
			6'd54: c = mk(K_A, MN_SW);
			6'd56: c = mk(K_B, MN_LBUI);
			6'd57: c = mk(K_B, MN_LHUI);
			6'd58: c = mk(K_B, MN_LWI);
			6'd60: c = mk(K_B, MN_SBI);
			6'd61: c = mk(K_B, MN_SHI);
			6'd62: c = mk(K_B, MN_SWI);
			default: c = mk(K_INV, MN_ADD);
		endcase
		return c;
	endfunction

	function automatic lookup_t lk(input logic hit, input logic [OffW-1:0] off);
		lookup_t r;
		r.hit = hit;
		r.off = off;
		return r;
	endfunction

	// Secondary opcode key lists; position in list is the offset
	function automatic lookup_t lk_cmp(input logic [10:0] k);
		unique case (k)
			11'h000: return lk(1'b1, 4'd0);
			11'h001: return lk(1'b1, 4'd1);
			11'h003: return lk(1'b1, 4'd2);
			default: return lk(1'b0, 4'd0);
		endcase
	endfunction

	function automatic lookup_t lk_mul(input logic [10:0] k);
		unique case (k)
			11'h000: return lk(1'b1, 4'd0);
			11'h001: return lk(1'b1, 4'd1);
			11'h003: return lk(1'b1, 4'd2);
			11'h002: return lk(1'b1, 4'd3);
			default: return lk(1'b0, 4'd0);
		endcase
	endfunction

	function automatic lookup_t lk_bs(input logic [10:0] k);
		unique case (k)
			11'h200: return lk(1'b1, 4'd0);
			11'h400: return lk(1'b1, 4'd1);
			default: return lk(1'b0, 4'd0);
		endcase
	endfunction

	function automatic lookup_t lk_idiv(input logic [10:0] k);
		unique case (k)
			11'h000: return lk(1'b1, 4'd0);
			11'h002: return lk(1'b1, 4'd1);
			default: return lk(1'b0, 4'd0);
		endcase
	endfunction

	function automatic lookup_t lk_flt(input logic [10:0] k);
		unique case (k)
			11'h000: return lk(1'b1, 4'd0);
			11'h080: return lk(1'b1, 4'd1);
			11'h100: return lk(1'b1, 4'd2);
			11'h180: return lk(1'b1, 4'd3);
			11'h200: return lk(1'b1, 4'd4);
			11'h210: return lk(1'b1, 4'd5);
			11'h220: return lk(1'b1, 4'd6);
			11'h230: return lk(1'b1, 4'd7);
			11'h240: return lk(1'b1, 4'd8);
			11'h250: return lk(1'b1, 4'd9);
			11'h260: return lk(1'b1, 4'd10);
			11'h280: return lk(1'b1, 4'd11);
			11'h300: return lk(1'b1, 4'd12);
			11'h380: return lk(1'b1, 4'd13);
			default: return lk(1'b0, 4'd0);
		endcase
	endfunction

	function automatic lookup_t lk_bsi(input logic [5:0] k);
		unique case (k)
			6'h00:   return lk(1'b1, 4'd0);
			6'h10:   return lk(1'b1, 4'd1);
			6'h20:   return lk(1'b1, 4'd2);
			default: return lk(1'b0, 4'd0);
		endcase
	endfunction

	function automatic lookup_t lk_pcmp(input logic [10:0] k);
		unique case (k)
			11'h000: return lk(1'b1, 4'd0);
			11'h400: return lk(1'b1, 4'd1);
			default: return lk(1'b0, 4'd0);
		endcase
	endfunction

	function automatic lookup_t lk_misc(input logic [10:0] k);
		unique case (k)
			11'h001: return lk(1'b1, 4'd0);
			11'h021: return lk(1'b1, 4'd1);
			11'h041: return lk(1'b1, 4'd2);
			11'h060: return lk(1'b1, 4'd3);
			11'h061: return lk(1'b1, 4'd4);
			11'h068: return lk(1'b1, 4'd5);
			11'h064: return lk(1'b1, 4'd6);
			default: return lk(1'b0, 4'd0);
		endcase
	endfunction

	function automatic lookup_t lk_br(input logic [RegW-1:0] k);
		unique case (k)
			5'h00:   return lk(1'b1, 4'd0);
			5'h10:   return lk(1'b1, 4'd1);
			5'h14:   return lk(1'b1, 4'd2);
			5'h08:   return lk(1'b1, 4'd3);
			5'h18:   return lk(1'b1, 4'd4);
			5'h1c:   return lk(1'b1, 4'd5);
			5'h0c:   return lk(1'b1, 4'd6);
			default: return lk(1'b0, 4'd0);
		endcase
	endfunction

	function automatic lookup_t lk_cond(input logic [RegW-1:0] k);
		unique case (k)
			5'h00:   return lk(1'b1, 4'd0);
			5'h01:   return lk(1'b1, 4'd1);
			5'h02:   return lk(1'b1, 4'd2);
			5'h03:   return lk(1'b1, 4'd3);
			5'h04:   return lk(1'b1, 4'd4);
			5'h05:   return lk(1'b1, 4'd5);
			5'h10:   return lk(1'b1, 4'd6);
			5'h11:   return lk(1'b1, 4'd7);
			5'h12:   return lk(1'b1, 4'd8);
			5'h13:   return lk(1'b1, 4'd9);
			5'h14:   return lk(1'b1, 4'd10);
			5'h15:   return lk(1'b1, 4'd11);
			default: return lk(1'b0, 4'd0);
		endcase
	endfunction

	function automatic lookup_t lk_rt(input logic [RegW-1:0] k);
		unique case (k)
			5'h10:   return lk(1'b1, 4'd0);
			5'h11:   return lk(1'b1, 4'd1);
			5'h12:   return lk(1'b1, 4'd2);
			5'h14:   return lk(1'b1, 4'd3);
			default: return lk(1'b0, 4'd0);
		endcase
	endfunction

endpackage

@@ rtl/scid_decode.sv @@
// Combinational decode of one instruction word into mnemonic, fields and branch target.
module scid_decode (
	input  logic [scid_pkg::WordW-1:0] instr_word,
	input  logic [scid_pkg::WordW-1:0] pc,
	output scid_pkg::dec_res_t         res
);

	logic [5:0]                     opc;
	logic [10:0]                    sec;
	logic [scid_pkg::RegW-1:0]      rd, ra, rb;
	logic [scid_pkg::ImmW-1:0]      imm;
	logic [scid_pkg::WordW-1:0]     sx, rel;
	scid_pkg::op_class_t            cls;
	scid_pkg::lookup_t              lu;
	logic                           hit;
	logic [scid_pkg::MnemW-1:0]     id;
	logic [scid_pkg::ImmW-1:0]      immo;
	logic [scid_pkg::WordW-1:0]     tgt;
	logic [scid_pkg::FlagW-1:0]     flags;
	logic                           is_get, is_put;

	assign opc = instr_word[31:26];
	assign sec = instr_word[10:0];
	assign rd  = instr_word[25:21];
	assign ra  = instr_word[20:16];
	assign rb  = instr_word[15:11];
	assign imm = instr_word[15:0];
	assign sx  = {{(scid_pkg::WordW-scid_pkg::ImmW){imm[scid_pkg::ImmW-1]}}, imm};
	assign rel = pc + sx;
	assign cls = scid_pkg::prim_class(opc);

	// get form wins when ra is zero and rd is not; else rd zero means put
	assign is_get = (ra == '0) && (rd != '0);
	assign is_put = !is_get && (rd == '0);

	always_comb begin
		lu    = scid_pkg::lk(1'b0, '0);
		hit   = 1'b0;
		id    = cls.id;
		immo  = '0;
		tgt   = '0;
		flags = '0;
		unique case (cls.kind)
			scid_pkg::K_A: begin
				hit = 1'b1;
			end
			scid_pkg::K_B, scid_pkg::K_IMM: begin
				hit  = 1'b1;
				immo = imm;
			end
			scid_pkg::K_CMP, scid_pkg::K_MUL, scid_pkg::K_BS, scid_pkg::K_IDIV,
			scid_pkg::K_FLT, scid_pkg::K_POR, scid_pkg::K_PXOR, scid_pkg::K_PANDN,
			scid_pkg::K_MISC: begin
				unique case (cls.kind)
					scid_pkg::K_CMP:  lu = scid_pkg::lk_cmp(sec);
					scid_pkg::K_MUL:  lu = scid_pkg::lk_mul(sec);
					scid_pkg::K_BS:   lu = scid_pkg::lk_bs(sec);
					scid_pkg::K_IDIV: lu = scid_pkg::lk_idiv(sec);
					scid_pkg::K_FLT:  lu = scid_pkg::lk_flt(sec);
					scid_pkg::K_MISC: lu = scid_pkg::lk_misc(sec);
					default:          lu = scid_pkg::lk_pcmp(sec);
				endcase
				hit = lu.hit;
				id  = cls.id + scid_pkg::MnemW'(lu.off);
			end
			scid_pkg::K_BSI: begin
				lu   = scid_pkg::lk_bsi(sec[10:5]);
				hit  = lu.hit;
				id   = cls.id + scid_pkg::MnemW'(lu.off);
				immo = scid_pkg::ImmW'(sec[4:0]);
			end
			scid_pkg::K_GETD: begin
				hit   = is_get || is_put;
				id    = cls.id + scid_pkg::MnemW'(!is_get);
				flags = {instr_word[7], instr_word[9], is_get & instr_word[5],
				         instr_word[8], instr_word[6]};
			end
			scid_pkg::K_GET: begin
				hit   = is_get || is_put;
				id    = cls.id + scid_pkg::MnemW'(!is_get);
				flags = {instr_word[12], instr_word[14], is_get & instr_word[10],
				         instr_word[13], instr_word[11]};
				immo  = scid_pkg::ImmW'(imm[3:0]);
			end
			scid_pkg::K_SPR: begin
				immo = scid_pkg::ImmW'(imm[13:0]);
				priority if (imm[15:14] == scid_pkg::SPR_MTS) begin
					hit = 1'b1;
					id  = scid_pkg::MN_MTS;
				end else if (imm[15:14] == scid_pkg::SPR_MFS) begin
					hit = 1'b1;
					id  = scid_pkg::MN_MFS;
				end else if (imm[15:14] == scid_pkg::SPR_MSR && ra == scid_pkg::RA_MSRCLR) begin
					hit = 1'b1;
					id  = scid_pkg::MN_MSRCLR;
				end else if (imm[15:14] == scid_pkg::SPR_MSR && ra == scid_pkg::RA_MSRSET) begin
					hit = 1'b1;
					id  = scid_pkg::MN_MSRSET;
				end else begin
					hit = 1'b0;
				end
			end
			scid_pkg::K_BRA: begin
				lu  = scid_pkg::lk_br(ra);
				hit = lu.hit;
				id  = cls.id + scid_pkg::MnemW'(lu.off);
			end
			scid_pkg::K_BRAC: begin
				lu  = scid_pkg::lk_cond(rd);
				hit = lu.hit;
				id  = cls.id + scid_pkg::MnemW'(lu.off);
			end
			scid_pkg::K_RT: begin
				lu   = scid_pkg::lk_rt(rd);
				hit  = lu.hit;
				id   = cls.id + scid_pkg::MnemW'(lu.off);
				immo = imm;
			end
			scid_pkg::K_BRI: begin
				lu   = scid_pkg::lk_br(ra);
				hit  = lu.hit;
				id   = cls.id + scid_pkg::MnemW'(lu.off);
				immo = imm;
				// first three list entries are pc-relative, the rest absolute
				tgt  = (lu.off <= scid_pkg::BRI_REL_LAST) ? rel : sx;
			end
			scid_pkg::K_BRIC: begin
				lu   = scid_pkg::lk_cond(rd);
				hit  = lu.hit;
				id   = cls.id + scid_pkg::MnemW'(lu.off);
				immo = imm;
				tgt  = rel;
			end
			default: begin
				hit = 1'b0;
			end
		endcase
	end

	// invalid encodings report all zeros
	always_comb begin
		res = '0;
		if (hit) begin
			res.valid_res     = 1'b1;
			res.mnemonic_id   = id;
			res.rd            = rd;
			res.ra            = ra;
			res.rb            = rb;
			res.imm_value     = immo;
			res.branch_target = tgt;
			res.mod_flags     = flags;
		end
	end

endmodule

@@ rtl/soft_cpu_instruction_decoder.sv @@
// Top level: input register, decode logic and output register of the instruction decoder.
//
// Decodes one 32-bit instruction word plus its pc per clock. A word taken on
// in_valid/in_ready lands in an input register. The decode (opcode class
// table, secondary key match, 32-bit pc + offset add) sits between that
// register and the output register. A word moves from the input register to
// the output register, raising out_valid, once that register is free or is
// being emptied. Throughput is one word per cycle, sustained as long
// as out_ready is high; each stage holds while the stage ahead is full and
// stalled, and in_ready drops only when both stages are full and out_ready is
// low. Invalid encodings still produce a result word, with every field zero.
// No configuration, no state beyond the two pipeline registers.
module soft_cpu_instruction_decoder (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [scid_pkg::WordW-1:0]         instr_word,
	input  logic [scid_pkg::WordW-1:0]         pc,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               valid_res,
	output logic [scid_pkg::MnemW-1:0]         mnemonic_id,
	output logic [scid_pkg::RegW-1:0]          rd,
	output logic [scid_pkg::RegW-1:0]          ra,
	output logic [scid_pkg::RegW-1:0]          rb,
	output logic [scid_pkg::ImmW-1:0]          imm_value,
	output logic [scid_pkg::WordW-1:0]         branch_target,
	output logic [scid_pkg::FlagW-1:0]         mod_flags
);

	// stage 1: captured word and pc
	logic                          valid_s1;
	logic [scid_pkg::WordW-1:0]    instr_s1;
	logic [scid_pkg::WordW-1:0]    pc_s1;
	// stage 2: decoded result
	logic                          valid_s2;
	scid_pkg::dec_res_t            res_s2;
	scid_pkg::dec_res_t            dec_res;
	logic                          ready_s2;

	// a stage takes a new word when empty or when its contents move on
	assign ready_s2 = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			instr_s1 <= instr_word;
			pc_s1    <= pc;
		end
	end

	scid_decode u_decode (
		.instr_word (instr_s1),
		.pc         (pc_s1),
		.res        (dec_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s2) begin
			res_s2 <= dec_res;
		end
	end

	assign out_valid     = valid_s2;
	assign valid_res     = res_s2.valid_res;
	assign mnemonic_id   = res_s2.mnemonic_id;
	assign rd            = res_s2.rd;
	assign ra            = res_s2.ra;
	assign rb            = res_s2.rb;
	assign imm_value     = res_s2.imm_value;
	assign branch_target = res_s2.branch_target;
	assign mod_flags     = res_s2.mod_flags;

endmodule

@@ tb/scid_tb_pkg.sv @@
// Opcode class table and secondary key lists shared by the decoder checker and stimulus.
`timescale 1ns / 100ps
package scid_tb_pkg;
	import scid_pkg::*;

	// Key lists that pick a mnemonic inside one opcode class
	typedef enum int {
		LS_NONE, LS_CMP, LS_MUL, LS_BS, LS_IDIV, LS_FLT, LS_BSI, LS_PCMP, LS_MISC,
		LS_BR, LS_COND, LS_RT
	} key_list_e;

	// Primary opcode -> class and base mnemonic
	function automatic op_class_t opcode_class(input logic [5:0] opc);
		op_class_t c;
		c = {K_INV, MN_ADD};
		case (opc)
			6'd0, 6'd1, 6'd2, 6'd3, 6'd4: c = {K_A, MN_ADD + opc};
			6'd5:                         c = {K_CMP, MN_CMP};
			6'd6, 6'd7:                   c = {K_A, MN_ADDKC + opc - 6'd6};
			6'd8, 6'd9, 6'd10, 6'd11,
			6'd12, 6'd13, 6'd14, 6'd15:   c = {K_B, MN_ADDI + opc - 6'd8};
			6'd16:                        c = {K_MUL, MN_MUL};
			6'd17:                        c = {K_BS, MN_BSRA};
			6'd18:                        c = {K_IDIV, MN_IDIV};
			6'd19:                        c = {K_GETD, MN_GETD};
			6'd22:                        c = {K_FLT, MN_FADD};
			6'd24:                        c = {K_B, MN_MULI};
			6'd25:                        c = {K_BSI, MN_BSRLI};
			6'd27:                        c = {K_GET, MN_GET};
			6'd32:                        c = {K_POR, MN_OR};
			6'd33:                        c = {K_A, MN_AND};
			6'd34:                        c = {K_PXOR, MN_XOR};
			6'd35:                        c = {K_PANDN, MN_ANDN};
			6'd36:                        c = {K_MISC, MN_SRA};
			6'd37:                        c = {K_SPR, MN_MTS};
			6'd38:                        c = {K_BRA, MN_BR};
			6'd39:                        c = {K_BRAC, MN_BEQ};
			6'd40, 6'd41, 6'd42, 6'd43:   c = {K_B, MN_ORI + opc - 6'd40};
			6'd44:                        c = {K_IMM, MN_IMM};
			6'd45:                        c = {K_RT, MN_RTSD};
			6'd46:                        c = {K_BRI, MN_BRI};
			6'd47:                        c = {K_BRIC, MN_BEQI};
			6'd48, 6'd49, 6'd50:          c = {K_A, MN_LBU + opc - 6'd48};
			6'd52, 6'd53, 6'd54:          c = {K_A, MN_SB + opc - 6'd52};
			6'd56, 6'd57, 6'd58:          c = {K_B, MN_LBUI + opc - 6'd56};
			6'd60, 6'd61, 6'd62:          c = {K_B, MN_SBI + opc - 6'd60};
			default:                      c = {K_INV, MN_ADD};
		endcase
		return c;
	endfunction

	function automatic key_list_e list_of(input kind_t k);
		case (k)
			K_CMP:                 return LS_CMP;
			K_MUL:                 return LS_MUL;
			K_BS:                  return LS_BS;
			K_IDIV:                return LS_IDIV;
			K_FLT:                 return LS_FLT;
			K_BSI:                 return LS_BSI;
			K_POR, K_PXOR, K_PANDN: return LS_PCMP;
			K_MISC:                return LS_MISC;
			K_BRA, K_BRI:          return LS_BR;
			K_BRAC, K_BRIC:        return LS_COND;
			K_RT:                  return LS_RT;
			default:               return LS_NONE;
		endcase
	endfunction

	function automatic int key_count(input key_list_e lst);
		case (lst)
			LS_CMP, LS_BSI:  return 3;
			LS_MUL, LS_RT:   return 4;
			LS_BS, LS_IDIV, LS_PCMP: return 2;
			LS_FLT:          return 14;
			LS_MISC, LS_BR:  return 7;
			LS_COND:         return 12;
			default:         return 0;
		endcase
	endfunction

	// Key at a list position; the position is the offset from the base mnemonic
	function automatic logic [10:0] key_at(input key_list_e lst, input int pos);
		logic [10:0] k;
		k = '0;
		case (lst)
			LS_CMP:
				case (pos)
					0: k = 11'h000;  1: k = 11'h001;  2: k = 11'h003;
					default: ;
				endcase
			LS_MUL:
				case (pos)
					0: k = 11'h000;  1: k = 11'h001;  2: k = 11'h003;  3: k = 11'h002;
					default: ;
				endcase
			LS_BS:
				case (pos)
					0: k = 11'h200;  1: k = 11'h400;
					default: ;
				endcase
			LS_IDIV:
				case (pos)
					0: k = 11'h000;  1: k = 11'h002;
					default: ;
				endcase
			LS_FLT:
				case (pos)
					0: k = 11'h000;  1: k = 11'h080;  2: k = 11'h100;  3: k = 11'h180;
					4: k = 11'h200;  5: k = 11'h210;  6: k = 11'h220;  7: k = 11'h230;
					8: k = 11'h240;  9: k = 11'h250;  10: k = 11'h260; 11: k = 11'h280;
					12: k = 11'h300; 13: k = 11'h380;
					default: ;
				endcase
			LS_BSI:
				case (pos)
					0: k = 11'h00;  1: k = 11'h10;  2: k = 11'h20;
					default: ;
				endcase
			LS_PCMP:
				case (pos)
					0: k = 11'h000;  1: k = 11'h400;
					default: ;
				endcase
			LS_MISC:
				case (pos)
					0: k = 11'h001;  1: k = 11'h021;  2: k = 11'h041;  3: k = 11'h060;
					4: k = 11'h061;  5: k = 11'h068;  6: k = 11'h064;
					default: ;
				endcase
			LS_BR:
				case (pos)
					0: k = 11'h00;  1: k = 11'h10;  2: k = 11'h14;  3: k = 11'h08;
					4: k = 11'h18;  5: k = 11'h1c;  6: k = 11'h0c;
					default: ;
				endcase
			LS_COND:
				case (pos)
					0: k = 11'h00;  1: k = 11'h01;  2: k = 11'h02;  3: k = 11'h03;
					4: k = 11'h04;  5: k = 11'h05;  6: k = 11'h10;  7: k = 11'h11;
					8: k = 11'h12;  9: k = 11'h13;  10: k = 11'h14; 11: k = 11'h15;
					default: ;
				endcase
			LS_RT:
				case (pos)
					0: k = 11'h10;  1: k = 11'h11;  2: k = 11'h12;  3: k = 11'h14;
					default: ;
				endcase
			default: ;
		endcase
		return k;
	endfunction

endpackage

@@ tb/scid_decode_checker.sv @@
// Decoder checker: predicts each decoded word and compares it with the block's output.
`timescale 1ns / 100ps
module scid_decode_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic [scid_pkg::WordW-1:0]  instr_word,
	input  logic [scid_pkg::WordW-1:0]  pc,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic                        valid_res,
	input  logic [scid_pkg::MnemW-1:0]  mnemonic_id,
	input  logic [scid_pkg::RegW-1:0]   rd,
	input  logic [scid_pkg::RegW-1:0]   ra,
	input  logic [scid_pkg::RegW-1:0]   rb,
	input  logic [scid_pkg::ImmW-1:0]   imm_value,
	input  logic [scid_pkg::WordW-1:0]  branch_target,
	input  logic [scid_pkg::FlagW-1:0]  mod_flags,
	output int                          err_cnt,
	output int                          pending
);
	import scid_pkg::*;
	import scid_tb_pkg::*;

	dec_res_t expected_decodes[$];
	dec_res_t want_res;

	initial begin
		err_cnt = 0;
		pending = 0;
	end

	function automatic int key_pos(input key_list_e lst, input logic [10:0] key);
		for (int k = 0; k < key_count(lst); k++)
			if (key_at(lst, k) == key)
				return k;
		return -1;
	endfunction

	function automatic dec_res_t decode_word(input logic [31:0] w, input logic [31:0] addr);
		op_class_t   cls;
		key_list_e   lst;
		logic [10:0] key;
		logic [15:0] imm, immo, src;
		logic [31:0] sx, rel, tgt;
		logic [4:0]  flags;
		int          id, pos, sh;
		bit          getd, is_get;
		dec_res_t    r;

		cls   = opcode_class(w[31:26]);
		imm   = w[15:0];
		sx    = {{16{imm[15]}}, imm};
		rel   = addr + sx;
		immo  = '0;
		tgt   = '0;
		flags = '0;
		id    = -1;
		pos   = -1;

		// secondary key: sec field, bsi sub-field, ra or rd by class
		case (cls.kind)
			K_BSI:                 key = {5'b0, w[10:5]};
			K_BRA, K_BRI:          key = {6'b0, w[20:16]};
			K_BRAC, K_BRIC, K_RT:  key = {6'b0, w[25:21]};
			default:               key = w[10:0];
		endcase
		lst = list_of(cls.kind);
		if (lst != LS_NONE) begin
			pos = key_pos(lst, key);
			if (pos >= 0)
				id = cls.id + pos;
		end

		case (cls.kind)
			K_A: id = cls.id;
			K_B, K_IMM: begin
				id   = cls.id;
				immo = imm;
			end
			K_BSI: immo = {11'b0, w[4:0]};
			K_RT:  immo = imm;
			K_BRI: begin
				immo = imm;
				tgt  = (pos >= 0 && pos <= int'(BRI_REL_LAST)) ? rel : sx;
			end
			K_BRIC: begin
				immo = imm;
				tgt  = rel;
			end
			K_GETD, K_GET: begin
				getd = (cls.kind == K_GETD);
				src  = getd ? {5'b0, w[10:0]} : imm;
				sh   = getd ? 0 : 5;
				if (w[20:16] == 0 && w[25:21] != 0) begin
					is_get = 1'b1;
					id     = cls.id;
				end else if (w[25:21] == 0) begin
					is_get = 1'b0;
					id     = cls.id + 1;
				end
				// t n e c a; put never carries e
				flags = {src[7 + sh], src[9 + sh], is_get & src[5 + sh], src[8 + sh], src[6 + sh]};
				if (!getd)
					immo = {12'b0, imm[3:0]};
			end
			K_SPR: begin
				if (imm[15:14] == SPR_MTS)
					id = MN_MTS;
				else if (imm[15:14] == SPR_MFS)
					id = MN_MFS;
				else if (imm[15:14] == SPR_MSR && w[20:16] == RA_MSRCLR)
					id = MN_MSRCLR;
				else if (imm[15:14] == SPR_MSR && w[20:16] == RA_MSRSET)
					id = MN_MSRSET;
				immo = {2'b0, imm[13:0]};
			end
			default: ;
		endcase

		r = '0;
		if (id >= 0) begin
			r.valid_res     = 1'b1;
			r.mnemonic_id   = id[MnemW-1:0];
			r.rd            = w[25:21];
			r.ra            = w[20:16];
			r.rb            = w[15:11];
			r.imm_value     = immo;
			r.branch_target = tgt;
			r.mod_flags     = flags;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("t=%0t mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
		err_cnt++;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				expected_decodes.push_back(decode_word(instr_word, pc));
			if (out_valid && out_ready) begin
				if (expected_decodes.size() == 0) begin
					report_mismatch("word with none expected", mnemonic_id, '0);
				end else begin
					want_res = expected_decodes.pop_front();
					if (valid_res !== want_res.valid_res)
						report_mismatch("valid_res", valid_res, want_res.valid_res);
					if (mnemonic_id !== want_res.mnemonic_id)
						report_mismatch("mnemonic_id", mnemonic_id, want_res.mnemonic_id);
					if (rd !== want_res.rd)
						report_mismatch("rd", rd, want_res.rd);
					if (ra !== want_res.ra)
						report_mismatch("ra", ra, want_res.ra);
					if (rb !== want_res.rb)
						report_mismatch("rb", rb, want_res.rb);
					if (imm_value !== want_res.imm_value)
						report_mismatch("imm_value", imm_value, want_res.imm_value);
					if (branch_target !== want_res.branch_target)
						report_mismatch("branch_target", branch_target, want_res.branch_target);
					if (mod_flags !== want_res.mod_flags)
						report_mismatch("mod_flags", mod_flags, want_res.mod_flags);
				end
			end
			pending = expected_decodes.size();
		end
	end

endmodule

@@ tb/tb_soft_cpu_instruction_decoder.sv @@
// Testbench top: drives instruction words into the decoder and gives the verdict.
`timescale 1ns / 100ps
module tb_soft_cpu_instruction_decoder;
	import scid_pkg::*;
	import scid_tb_pkg::*;

	localparam int ITEMS_PER_PHASE = 442;
	// far beyond the slowest legal run (~1400 words, heavy stalls)
	localparam int TIMEOUT_NS      = 2_000_000;
	// drain margin after the last result: two pipeline stages plus slack
	localparam int DRAIN_CYCLES    = 10;

	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 in_valid    = 1'b0;
	logic [WordW-1:0]     instr_word  = '0;
	logic [WordW-1:0]     pc          = '0;
	logic                 out_ready   = 1'b0;
	logic                 in_ready;
	logic                 out_valid;
	logic                 valid_res;
	logic [MnemW-1:0]     mnemonic_id;
	logic [RegW-1:0]      rd, ra, rb;
	logic [ImmW-1:0]      imm_value;
	logic [WordW-1:0]     branch_target;
	logic [FlagW-1:0]     mod_flags;
	int                   err_cnt;
	int                   pending;

	// percent of cycles each side sits idle; changed between phases
	int                   send_idle_pct = 11;
	int                   recv_idle_pct = 45;

	// 8 ns clock
	always #4 clk = ~clk;

	soft_cpu_instruction_decoder u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.instr_word    (instr_word),
		.pc            (pc),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.valid_res     (valid_res),
		.mnemonic_id   (mnemonic_id),
		.rd            (rd),
		.ra            (ra),
		.rb            (rb),
		.imm_value     (imm_value),
		.branch_target (branch_target),
		.mod_flags     (mod_flags)
	);

	// Checker sits beside the block and watches both channels
	scid_decode_checker u_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.instr_word    (instr_word),
		.pc            (pc),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.valid_res     (valid_res),
		.mnemonic_id   (mnemonic_id),
		.rd            (rd),
		.ra            (ra),
		.rb            (rb),
		.imm_value     (imm_value),
		.branch_target (branch_target),
		.mod_flags     (mod_flags),
		.err_cnt       (err_cnt),
		.pending       (pending)
	);

	// Result side: ready re-rolled each falling edge, so stalls land on any pipeline phase
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// First opcode of a given class
	function automatic logic [5:0] opcode_for(input kind_t k);
		op_class_t cls;
		for (int opc = 0; opc < 64; opc++) begin
			cls = opcode_class(opc[5:0]);
			if (cls.kind == k)
				return opc[5:0];
		end
		return '0;
	endfunction

	// Drop the list key for position pos into the field the class decodes it from
	function automatic logic [31:0] place_key(input logic [31:0] w, input kind_t k,
		input int pos);
		logic [10:0] key;
		key = key_at(list_of(k), pos);
		case (k)
			K_BSI:                w[10:5]  = key[5:0];
			K_BRA, K_BRI:         w[20:16] = key[4:0];
			K_BRAC, K_BRIC, K_RT: w[25:21] = key[4:0];
			default:              w[10:0]  = key;
		endcase
		return w;
	endfunction

	// Word of class k with given register fields and low half; pos < 0 keeps the raw bits
	function automatic logic [31:0] encode_word(input kind_t k, input int pos,
		input logic [4:0] f_rd, input logic [4:0] f_ra, input logic [15:0] imm);
		logic [31:0] w;
		w = {opcode_for(k), f_rd, f_ra, imm};
		if (pos >= 0)
			w = place_key(w, k, pos);
		return w;
	endfunction

	// Mostly well-formed words with random content; the rest is raw noise,
	// which also reaches the unused opcodes and unmatched sub-fields.
	function automatic logic [31:0] random_word();
		logic [31:0] w;
		logic [5:0]  opc;
		op_class_t   cls;
		key_list_e   lst;
		w = $urandom;
		if ($urandom_range(99) < 80) begin
			do begin
				opc = $urandom_range(63);
				cls = opcode_class(opc);
			end while (cls.kind == K_INV);
			w[31:26] = opc;
			lst = list_of(cls.kind);
			// a few keep their random key so near-miss encodings show up too
			if (lst != LS_NONE && $urandom_range(9) != 0)
				w = place_key(w, cls.kind, $urandom_range(key_count(lst) - 1));
			case (cls.kind)
				K_GETD, K_GET:
					case ($urandom_range(2))
						0: w[20:16] = '0;   // get form if rd nonzero
						1: w[25:21] = '0;   // put form
						default: ;          // mostly invalid combination
					endcase
				K_SPR:
					case ($urandom_range(3))
						0: begin
							w[15:14] = SPR_MSR;
							w[20:16] = RA_MSRCLR;
						end
						1: begin
							w[15:14] = SPR_MSR;
							w[20:16] = RA_MSRSET;
						end
						default: ;
					endcase
				default: ;
			endcase
		end
		return w;
	endfunction

	// One word on the input channel: optional idle gap, then hold valid until taken
	task automatic send_word(input logic [31:0] w, input logic [31:0] addr);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		instr_word <= w;
		pc         <= addr;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Run limit, independent of the stimulus flow
	initial begin
		#(TIMEOUT_NS);
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		logic [31:0] addr;

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: field extremes and the corner encodings
		send_word('0, '0);                                          // add r0,r0,r0
		send_word('1, '1);                                          // unused top opcode
		// relative branch, negative offset from pc zero
		send_word(encode_word(K_BRI, 0, 5'd0, 5'd0, 16'h8000), 32'h0000_0000);
		// relative branch wrapping past the top of the address space
		send_word(encode_word(K_BRI, 1, 5'd31, 5'd0, 16'h7fff), 32'hffff_ffff);
		// absolute forms ignore pc, then a relative conditional branch
		send_word(encode_word(K_BRI, 3, 5'd1, 5'd0, 16'h8000), 32'h1234_5678);
		send_word(encode_word(K_BRI, 6, 5'd0, 5'd0, 16'hffff), 32'h0000_0010);
		send_word(encode_word(K_BRIC, 11, 5'd0, 5'd9, 16'h8001), 32'h8000_0000);
		// ra not a branch key
		send_word(encode_word(K_BRI, -1, 5'd0, 5'd1, 16'h0004), 32'h0000_0100);
		// get / put choice: get, put with ra ignored, neither
		send_word(encode_word(K_GET, -1, 5'd5, 5'd0, 16'h7fff), 32'h0);
		send_word(encode_word(K_GET, -1, 5'd0, 5'd7, 16'h7fff), 32'h0);
		send_word(encode_word(K_GET, -1, 5'd3, 5'd2, 16'h7fff), 32'h0);
		send_word(encode_word(K_GETD, -1, 5'd1, 5'd0, 16'h03e0), 32'h0);
		send_word(encode_word(K_GETD, -1, 5'd0, 5'd0, 16'hffff), 32'h0);
		// special register forms, including the unused select and a bad msr ra
		send_word(encode_word(K_SPR, -1, 5'd2, 5'd3, {SPR_MTS, 14'h3fff}), 32'h0);
		send_word(encode_word(K_SPR, -1, 5'd2, 5'd3, {SPR_MFS, 14'h0000}), 32'h0);
		send_word(encode_word(K_SPR, -1, 5'd31, RA_MSRCLR, {SPR_MSR, 14'h3fff}), 32'h0);
		send_word(encode_word(K_SPR, -1, 5'd0, RA_MSRSET, {SPR_MSR, 14'h0001}), 32'h0);
		send_word(encode_word(K_SPR, -1, 5'd4, RA_MSRCLR + 5'd1, {SPR_MSR, 14'h0}), 32'h0);
		send_word(encode_word(K_SPR, -1, 5'd4, RA_MSRCLR, {2'(SPR_MSR + 1), 14'h0}), 32'h0);
		// immediate shift: largest amount, then an unlisted sub-opcode
		send_word(encode_word(K_BSI, 2, 5'd31, 5'd31, 16'hf81f), 32'h0);
		send_word(encode_word(K_BSI, -1, 5'd1, 5'd1, 16'h0020), 32'h0);
		send_word({opcode_for(K_INV), 26'h3ff_ffff}, 32'hdead_0000);
		send_word(encode_word(K_FLT, 13, 5'd7, 5'd8, 16'h4800), 32'h0);
		send_word(encode_word(K_MISC, -1, 5'd7, 5'd8, 16'h0002), 32'h0);
		send_word(encode_word(K_RT, 3, 5'd0, 5'd15, 16'hffff), 32'hffff_fff0);

		// Random: sender light / receiver heavy, then swapped, then back to back
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 11 : (ph == 1) ? 45 : 0;
			recv_idle_pct = (ph == 0) ? 45 : (ph == 1) ? 11 : 0;
			repeat (ITEMS_PER_PHASE) begin
				addr = $urandom;
				if ($urandom_range(15) == 0)
					addr = {32{addr[0]}};   // pc at either extreme
				send_word(random_word(), addr);
			end
		end
		in_valid <= 1'b0;

		// Drain; a stuck pipeline is caught by the run limit
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (err_cnt == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ soft_cpu_instruction_decoder.f @@
rtl/scid_pkg.sv
rtl/scid_decode.sv
rtl/soft_cpu_instruction_decoder.sv
tb/scid_tb_pkg.sv
tb/scid_decode_checker.sv
tb/tb_soft_cpu_instruction_decoder.sv
